FILE: rtl/stfe_pkg.sv
package stfe_pkg;

	// node capacity and derived widths
	localparam int MAX_NODES = 64;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int CFG_W     = 7;
	localparam int KEPT_W    = 6;
	localparam int NCNT_W    = (CFG_W > NODE_W + 1) ? CFG_W : NODE_W + 1;
	localparam int WALK_W    = NODE_W + 1;

	localparam logic [KEPT_W-1:0] KEPT_MAX = '1;

	// configuration register map
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic [ADDR_W-1:0] ADDR_NODE_COUNT = 3'd0;
	localparam logic [CFG_W-1:0]  NODE_COUNT_RST  = CFG_W'(MAX_NODES);

	typedef logic [NODE_W-1:0] label_t;

	typedef struct packed {
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
		logic              first_edge;
		logic              last_edge;
	} req_item_t;

	typedef struct packed {
		logic              keep_edge;
		logic [KEPT_W-1:0] kept_total;
		logic              tree_complete;
	} rsp_item_t;

	// access request from the control logic to the label memory
	typedef struct packed {
		logic   clear;
		logic   rd_en;
		label_t rd_addr;
		logic   wr_en;
		label_t wr_addr;
		label_t wr_data;
	} mem_req_t;

endpackage

FILE: rtl/stfe_label_mem.sv
module stfe_label_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  stfe_pkg::mem_req_t mem_req,
	output stfe_pkg::label_t   rd_label
);
	import stfe_pkg::*;

	label_t               mem [MAX_NODES];
	logic [MAX_NODES-1:0] valid_q;
	label_t               rd_data_s1;
	label_t               rd_idx_s1;
	logic                 rd_valid_s1;

	// label storage, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			mem[mem_req.wr_addr] <= mem_req.wr_data;
		end
		if (mem_req.rd_en) begin
			rd_data_s1 <= mem[mem_req.rd_addr];
			rd_idx_s1  <= mem_req.rd_addr;
		end
	end

	// per-entry valid bits, an unwritten entry reads as its own index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (mem_req.rd_en) begin
				rd_valid_s1 <= valid_q[mem_req.rd_addr] && !mem_req.clear;
			end
			if (mem_req.clear) begin
				valid_q <= '0;
			end else if (mem_req.wr_en) begin
				valid_q[mem_req.wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_label = rd_valid_s1 ? rd_data_s1 : rd_idx_s1;

endmodule

FILE: rtl/spanning_tree_edge_filter.sv
// Kruskal spanning-tree edge filter.
// Edges arrive on the req channel (req_valid/req_stall/req_data), sorted by
// descending weight. Each edge gives exactly one result on the rsp channel:
// whether it was kept, the running kept count and, on the last edge, whether
// the kept edges form a full spanning tree over node_count nodes.
// node_count is written over the APB port at byte address 0; the user must
// write it only while idle, as the block does not enforce this.
// A dropped edge passes through the states RDA, RDB and CMP to FIN, where the
// result register is loaded; a kept edge also runs a merge walk between CMP
// and FIN that reads every label in the label memory, one read per cycle,
// and writes back each matching label. One edge is in work at a time;
// req_stall is high until its result is loaded, so no new edge is taken before.
// The result register frees the input side: the next edge is taken while a
// result waits. If rsp_stall holds a result, the following result waits in
// its final state and req_stall stays high.
// Reset clears all labels to their own index, the kept count to zero and
// node_count to 64; a first_edge transfer restores labels and count at once.
module spanning_tree_edge_filter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  req_valid,
	output logic                                  req_stall,
	input  stfe_pkg::req_item_t                   req_data,
	output logic                                  rsp_valid,
	input  logic                                  rsp_stall,
	output stfe_pkg::rsp_item_t                   rsp_data,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [stfe_pkg::ADDR_W-1:0]           paddr,
	input  logic [stfe_pkg::DATA_W-1:0]           pwdata,
	output logic [stfe_pkg::DATA_W-1:0]           prdata,
	output logic                                  pready
);
	import stfe_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RDA  = 6'b000010,
		S_RDB  = 6'b000100,
		S_CMP  = 6'b001000,
		S_WALK = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  node_count_q;
	logic [NCNT_W-1:0] n_sat;
	req_item_t         item_q;
	logic              in_range_q;
	logic              keep_q;
	logic [KEPT_W-1:0] kept_q;
	label_t            la_q;
	label_t            lb_q;
	logic [WALK_W-1:0] walk_cnt_q;
	logic              walk_vld_s1;
	label_t            walk_idx_s1;
	logic              rsp_valid_q;
	rsp_item_t         rsp_data_q;
	mem_req_t          mem_req;
	label_t            rd_label;
	logic              req_xfer;
	logic              cfg_wr;
	logic              rsp_free;
	logic              complete;
	logic              walk_end;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_NODE_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
		end else if (cfg_wr) begin
			node_count_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_NODE_COUNT) begin
			prdata[CFG_W-1:0] = node_count_q;
		end
	end

	// active node count, saturated at capacity
	assign n_sat = (NCNT_W'(node_count_q) > NCNT_W'(MAX_NODES)) ?
		NCNT_W'(MAX_NODES) : NCNT_W'(node_count_q);

	assign req_stall = (state_q != S_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign walk_end  = (walk_cnt_q == WALK_W'(MAX_NODES));
	assign complete  = item_q.last_edge && (n_sat != '0) &&
		(NCNT_W'(kept_q) == n_sat - 1'b1);

	// label memory accesses
	always_comb begin
		mem_req         = '0;
		mem_req.clear   = req_xfer && req_data.first_edge;
		mem_req.rd_addr = item_q.node_a;
		case (state_q)
			S_RDA: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = item_q.node_a;
			end
			S_RDB: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = item_q.node_b;
			end
			S_WALK: begin
				mem_req.rd_en   = !walk_end;
				mem_req.rd_addr = walk_cnt_q[NODE_W-1:0];
				mem_req.wr_en   = walk_vld_s1 && (rd_label == lb_q);
				mem_req.wr_addr = walk_idx_s1;
				mem_req.wr_data = la_q;
			end
			default: begin
			end
		endcase
	end

	stfe_label_mem u_label_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.mem_req  (mem_req),
		.rd_label (rd_label)
	);

	// item payload and label holding registers
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			item_q     <= req_data;
			in_range_q <= (NCNT_W'(req_data.node_a) < n_sat) &&
				(NCNT_W'(req_data.node_b) < n_sat);
		end
		if (state_q == S_RDB) begin
			la_q <= rd_label;
		end
		if (state_q == S_CMP) begin
			lb_q <= rd_label;
		end
		walk_idx_s1 <= walk_cnt_q[NODE_W-1:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kept_q      <= '0;
			keep_q      <= 1'b0;
			walk_cnt_q  <= '0;
			walk_vld_s1 <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						keep_q  <= 1'b0;
						state_q <= S_RDA;
						if (req_data.first_edge) begin
							kept_q <= '0;
						end
					end
				end
				S_RDA: begin
					state_q <= S_RDB;
				end
				S_RDB: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (in_range_q && (la_q != rd_label)) begin
						keep_q     <= 1'b1;
						walk_cnt_q <= '0;
						state_q    <= S_WALK;
						if (kept_q != KEPT_MAX) begin
							kept_q <= kept_q + 1'b1;
						end
					end else begin
						state_q <= S_FIN;
					end
				end
				S_WALK: begin
					// read one label per cycle, write it back in the next cycle
					if (walk_end) begin
						walk_vld_s1 <= 1'b0;
						state_q     <= S_FIN;
					end else begin
						walk_vld_s1 <= 1'b1;
						walk_cnt_q  <= walk_cnt_q + 1'b1;
					end
				end
				S_FIN: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == S_FIN) && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FIN) && rsp_free) begin
			rsp_data_q.keep_edge     <= keep_q;
			rsp_data_q.kept_total    <= kept_q;
			rsp_data_q.tree_complete <= complete;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	// label writes only happen during a merge walk
	a_wr_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> (state_q == S_WALK))
		else $error("label write outside merge walk");

	// a merge walk covers every label and then finishes
	a_walk_len: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_WALK) |-> ##65 (state_q == S_FIN))
		else $error("merge walk length wrong");

	// a kept edge always reports a nonzero count
	a_keep_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.keep_edge) |-> (rsp_data.kept_total != '0))
		else $error("kept edge with zero count");

	// a result is loaded only when the output slot is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
		else $error("held result overwritten");

endmodule
